// ===== rtl/lmts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_pkg: shared types and constants of the LED matrix text scroller
// Transfer payloads, command codes, controller/datapath interface structs,
// chain register codes and the 5x7 font.
// ----------------------------------------------------------------------------
package lmts_pkg;

  // Input transfer: one command item
  typedef struct packed {
    logic [1:0] command;
    logic [6:0] char_code;
    logic [5:0] char_pos;
  } lmts_in_t;

  // Output transfer: one chain frame
  typedef struct packed {
    logic [63:0] chain_frame;
    logic        last_of_run;
    logic        pass_done;
  } lmts_out_t;

  // Command codes; the fourth code is ignored
  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_STEP  = 2'd2
  } lmts_cmd_code_t;

  // Configuration register indexes
  localparam logic REG_IDX_INTENSITY = 1'b0;
  localparam logic REG_IDX_TEXT_LEN  = 1'b1;

  // Driver register codes sent down the chain
  localparam logic [7:0] DRV_DISPLAY_TEST = 8'h0F;
  localparam logic [7:0] DRV_DECODE_MODE  = 8'h09;
  localparam logic [7:0] DRV_SCAN_LIMIT   = 8'h0B;
  localparam logic [7:0] DRV_INTENSITY    = 8'h0A;
  localparam logic [7:0] DRV_SHUTDOWN     = 8'h0C;
  localparam logic [7:0] DRV_DIGIT0       = 8'h01;
  localparam logic [7:0] SCAN_ALL_ROWS    = 8'h07;
  localparam logic [7:0] SHUTDOWN_NORMAL  = 8'h01;

  // Frame sequencing
  localparam logic [3:0] INIT_LAST   = 4'd12;
  localparam logic [3:0] ROW_LAST    = 4'd7;
  localparam logic [3:0] INIT_DIGITS = 4'd5;

  // Font geometry
  localparam int PITCH   = 6;
  localparam int GLYPH_W = 5;
  localparam logic [6:0] FONT_FIRST = 7'h20;
  localparam logic [6:0] FONT_LAST  = 7'h5A;

  // Controller to datapath commands
  typedef struct packed {
    logic       mem_write;
    logic       start_init;
    logic       start_render;
    logic       col_write;
    logic       finish;
    logic       emit_init;
    logic       emit_row;
    logic [3:0] frm_idx;
  } lmts_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic col_last;
  } lmts_sts_t;

  // Register/data pair of init frame k
  function automatic logic [15:0] init_pair(input logic [3:0] k, input logic [3:0] inten);
    logic [15:0] p;
    case (k)
      4'd0:    p = {DRV_DISPLAY_TEST, 8'h00};
      4'd1:    p = {DRV_DECODE_MODE, 8'h00};
      4'd2:    p = {DRV_SCAN_LIMIT, SCAN_ALL_ROWS};
      4'd3:    p = {DRV_INTENSITY, 4'h0, inten};
      4'd4:    p = {DRV_SHUTDOWN, SHUTDOWN_NORMAL};
      default: p = {DRV_DIGIT0 + {4'h0, k - INIT_DIGITS}, 8'h00};
    endcase
    return p;
  endfunction

  // Five columns of a glyph, column 0 in the top byte
  function automatic logic [39:0] glyph_row(input logic [5:0] idx);
    logic [39:0] r;
    case (idx)
      6'd0:  r = 40'h00_00_00_00_00;
      6'd1:  r = 40'h00_00_5F_00_00;
      6'd2:  r = 40'h00_07_00_07_00;
      6'd3:  r = 40'h14_7F_14_7F_14;
      6'd4:  r = 40'h24_2A_7F_2A_12;
      6'd5:  r = 40'h23_13_08_64_62;
      6'd6:  r = 40'h36_49_55_22_50;
      6'd7:  r = 40'h00_05_03_00_00;
      6'd8:  r = 40'h00_1C_22_41_00;
      6'd9:  r = 40'h00_41_22_1C_00;
      6'd10: r = 40'h14_08_3E_08_14;
      6'd11: r = 40'h08_08_3E_08_08;
      6'd12: r = 40'h00_50_30_00_00;
      6'd13: r = 40'h08_08_08_08_08;
      6'd14: r = 40'h00_60_60_00_00;
      6'd15: r = 40'h20_10_08_04_02;
      6'd16: r = 40'h3E_51_49_45_3E;
      6'd17: r = 40'h00_42_7F_40_00;
      6'd18: r = 40'h42_61_51_49_46;
      6'd19: r = 40'h21_41_45_4B_31;
      6'd20: r = 40'h18_14_12_7F_10;
      6'd21: r = 40'h27_45_45_45_39;
      6'd22: r = 40'h3C_4A_49_49_30;
      6'd23: r = 40'h01_71_09_05_03;
      6'd24: r = 40'h36_49_49_49_36;
      6'd25: r = 40'h06_49_49_29_1E;
      6'd26: r = 40'h00_36_36_00_00;
      6'd27: r = 40'h00_56_36_00_00;
      6'd28: r = 40'h08_14_22_41_00;
      6'd29: r = 40'h14_14_14_14_14;
      6'd30: r = 40'h00_41_22_14_08;
      6'd31: r = 40'h02_01_51_09_06;
      6'd32: r = 40'h32_49_59_51_3E;
      6'd33: r = 40'h7E_11_11_11_7E;
      6'd34: r = 40'h7F_49_49_49_36;
      6'd35: r = 40'h3E_41_41_41_22;
      6'd36: r = 40'h7F_41_41_22_1C;
      6'd37: r = 40'h7F_49_49_49_41;
      6'd38: r = 40'h7F_09_09_09_01;
      6'd39: r = 40'h3E_41_49_49_7A;
      6'd40: r = 40'h7F_08_08_08_7F;
      6'd41: r = 40'h00_41_7F_41_00;
      6'd42: r = 40'h20_40_41_3F_01;
      6'd43: r = 40'h7F_08_14_22_41;
      6'd44: r = 40'h7F_40_40_40_40;
      6'd45: r = 40'h7F_02_0C_02_7F;
      6'd46: r = 40'h7F_04_08_10_7F;
      6'd47: r = 40'h3E_41_41_41_3E;
      6'd48: r = 40'h7F_09_09_09_06;
      6'd49: r = 40'h3E_41_51_21_5E;
      6'd50: r = 40'h7F_09_19_29_46;
      6'd51: r = 40'h46_49_49_49_31;
      6'd52: r = 40'h01_01_7F_01_01;
      6'd53: r = 40'h3F_40_40_40_3F;
      6'd54: r = 40'h1F_20_40_20_1F;
      6'd55: r = 40'h3F_40_38_40_3F;
      6'd56: r = 40'h63_14_08_14_63;
      6'd57: r = 40'h07_08_70_08_07;
      6'd58: r = 40'h61_51_49_45_43;
      default: r = 40'h00_00_00_00_00;
    endcase
    return r;
  endfunction

  // One glyph column; columns past the glyph width read blank
  function automatic logic [7:0] glyph_col(input logic [5:0] idx, input logic [2:0] cc);
    logic [39:0] r;
    logic [7:0]  c;
    r = glyph_row(idx);
    case (cc)
      3'd0:    c = r[39:32];
      3'd1:    c = r[31:24];
      3'd2:    c = r[23:16];
      3'd3:    c = r[15:8];
      3'd4:    c = r[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lmts_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lmts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/lmts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_ctrl: command sequencer of the text scroller
// Accepts one command at a time, walks the screen columns and counts frames.
// ----------------------------------------------------------------------------
module lmts_ctrl import lmts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire lmts_sts_t  sts,
  output lmts_ctl_t       ctl
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_ADDR = 5'b00100,
    ST_DATA = 5'b01000,
    ST_ROWS = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] frm_r, frm_nxt;
  logic       take;

  assign in_ready = (state_r == ST_IDLE);
  assign take     = in_valid && in_ready;

  // Decode state into datapath commands and next state
  always_comb begin
    state_nxt = state_r;
    frm_nxt   = frm_r;
    ctl       = '0;
    ctl.frm_idx = frm_r;
    case (state_r)
      ST_IDLE: begin
        frm_nxt = 4'd0;
        if (take) begin
          if (in_command == CMD_INIT) begin
            ctl.start_init = 1'b1;
            state_nxt      = ST_INIT;
          end else if (in_command == CMD_WRITE) begin
            ctl.mem_write = 1'b1;
          end else if (in_command == CMD_STEP) begin
            ctl.start_render = 1'b1;
            state_nxt        = ST_ADDR;
          end
        end
      end
      ST_INIT: begin
        if (sts.out_free) begin
          ctl.emit_init = 1'b1;
          if (frm_r == INIT_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            frm_nxt = frm_r + 4'd1;
          end
        end
      end
      ST_ADDR: begin
        // text RAM read in flight
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        ctl.col_write = 1'b1;
        if (sts.col_last) begin
          ctl.finish = 1'b1;
          state_nxt  = ST_ROWS;
        end else begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ROWS: begin
        if (sts.out_free) begin
          ctl.emit_row = 1'b1;
          if (frm_r == ROW_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            frm_nxt = frm_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and frame counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      frm_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      frm_r   <= frm_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lmts_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmts_dp: datapath of the text scroller
// Text RAM, scroll offset, column cursor, screen columns and output register.
// ----------------------------------------------------------------------------
module lmts_dp import lmts_pkg::*; #(
  parameter int MODULES  = 4,
  parameter int TEXT_MAX = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lmts_ctl_t  ctl,
  output lmts_sts_t       sts,
  input  wire logic [6:0] char_code,
  input  wire logic [5:0] char_pos,
  input  wire logic [3:0] intensity,
  input  wire logic [6:0] text_length,
  output logic            out_valid,
  input  wire logic       out_ready,
  output lmts_out_t       out_item
);

  localparam int NCOL  = 8 * MODULES;
  localparam int COL_W = $clog2(NCOL);
  localparam int AW    = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam int LEN_W = $clog2(TEXT_MAX + 1);
  localparam int OFS_W = $clog2(PITCH * TEXT_MAX + NCOL + 2) + 1;
  localparam int CI_W  = $clog2(TEXT_MAX + NCOL + 1) + 1;
  localparam logic [OFS_W-1:0] SCREEN_COLS = OFS_W'(NCOL);

  logic [OFS_W-1:0] offset_r, offset_nxt;
  logic [CI_W-1:0]  bci_r, bci_nxt;
  logic [2:0]       bcc_r, bcc_nxt;
  logic [OFS_W:0]   rel_r, rel_nxt;
  logic [CI_W-1:0]  ci_r, ci_nxt;
  logic [2:0]       cc_r, cc_nxt;
  logic             done_r, done_nxt;
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  lmts_out_t        out_item_r;
  logic [7:0]       col_r [NCOL];

  logic [LEN_W-1:0] len;
  logic [OFS_W-1:0] len_x, six_len;
  logic [OFS_W:0]   pass_sum;
  logic             done_now, offset_le0;
  logic             mem_we;
  logic [6:0]       ram_q;
  logic [5:0]       gidx;
  logic [7:0]       gbits;
  logic             col_on;
  logic             emit;
  logic             last;
  logic [15:0]      pair;
  logic [7:0]       rbyte;
  logic [63:0]      frame;

  // Text store
  assign mem_we = ctl.mem_write && (int'(char_pos) < TEXT_MAX);

  lmts_ram #(
    .WIDTH (7),
    .DEPTH (TEXT_MAX),
    .AW    (AW)
  ) u_text_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(char_pos)),
    .wdata (char_code),
    .raddr (ci_r[AW-1:0]),
    .rdata (ram_q)
  );

  // Clamp length and test for the end of the pass: offset <= -6*len
  always_comb begin
    if (int'(text_length) > TEXT_MAX) begin
      len = LEN_W'(TEXT_MAX);
    end else begin
      len = LEN_W'(text_length);
    end
    len_x      = OFS_W'(len);
    six_len    = (len_x << 2) + (len_x << 1);
    pass_sum   = {offset_r[OFS_W-1], offset_r} + {1'b0, six_len};
    done_now   = pass_sum[OFS_W] || (pass_sum == '0);
    offset_le0 = offset_r[OFS_W-1] || (offset_r == '0);
  end

  // Glyph column under the cursor
  always_comb begin
    if ((ram_q < FONT_FIRST) || (ram_q > FONT_LAST)) begin
      gidx = 6'd0;
    end else begin
      gidx = 6'(ram_q - FONT_FIRST);
    end
    gbits  = glyph_col(gidx, cc_r);
    col_on = !rel_r[OFS_W] && (ci_r < CI_W'(len)) && (cc_r < 3'(GLYPH_W));
  end

  // Offset, base cursor and column cursor updates
  always_comb begin
    offset_nxt  = offset_r;
    bci_nxt     = bci_r;
    bcc_nxt     = bcc_r;
    rel_nxt     = rel_r;
    ci_nxt      = ci_r;
    cc_nxt      = cc_r;
    done_nxt    = done_r;
    col_cnt_nxt = col_cnt_r;
    if (ctl.start_init) begin
      offset_nxt = SCREEN_COLS;
      bci_nxt    = '0;
      bcc_nxt    = 3'd0;
    end
    if (ctl.start_render) begin
      rel_nxt     = '0 - {offset_r[OFS_W-1], offset_r};
      ci_nxt      = bci_r;
      cc_nxt      = bcc_r;
      done_nxt    = done_now;
      col_cnt_nxt = '0;
    end
    if (ctl.col_write) begin
      col_cnt_nxt = col_cnt_r + COL_W'(1);
      if (rel_r[OFS_W]) begin
        rel_nxt = rel_r + 1'b1;
      end else if (cc_r == 3'(PITCH - 1)) begin
        cc_nxt = 3'd0;
        ci_nxt = ci_r + 1'b1;
      end else begin
        cc_nxt = cc_r + 3'd1;
      end
    end
    if (ctl.finish) begin
      if (done_r) begin
        offset_nxt = SCREEN_COLS;
        bci_nxt    = '0;
        bcc_nxt    = 3'd0;
      end else begin
        offset_nxt = offset_r - 1'b1;
        // advance base only once the first column sits at or right of text start
        if (offset_le0) begin
          if (bcc_r == 3'(PITCH - 1)) begin
            bcc_nxt = 3'd0;
            bci_nxt = bci_r + 1'b1;
          end else begin
            bcc_nxt = bcc_r + 3'd1;
          end
        end
      end
    end
  end

  // Assemble the outgoing frame
  always_comb begin
    frame = '0;
    pair  = init_pair(ctl.frm_idx, intensity);
    rbyte = 8'h00;
    for (int m = 0; m < MODULES; m++) begin
      for (int j = 0; j < 8; j++) begin
        rbyte[7 - j] = col_r[m * 8 + j][ctl.frm_idx[2:0]];
      end
      if (ctl.emit_init) begin
        frame[m * 16 +: 16] = pair;
      end else begin
        frame[m * 16 +: 16] = {DRV_DIGIT0 + {5'd0, ctl.frm_idx[2:0]}, rbyte};
      end
    end
  end

  assign emit = ctl.emit_init || ctl.emit_row;
  assign last = (ctl.emit_init && (ctl.frm_idx == INIT_LAST)) ||
                (ctl.emit_row && (ctl.frm_idx == ROW_LAST));

  // Hold a frame until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= SCREEN_COLS;
      bci_r       <= '0;
      bcc_r       <= 3'd0;
      done_r      <= 1'b0;
      col_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      offset_r    <= offset_nxt;
      bci_r       <= bci_nxt;
      bcc_r       <= bcc_nxt;
      done_r      <= done_nxt;
      col_cnt_r   <= col_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rel_r <= rel_nxt;
    ci_r  <= ci_nxt;
    cc_r  <= cc_nxt;
    if (ctl.col_write) begin
      col_r[col_cnt_r] <= col_on ? gbits : 8'h00;
    end
    if (emit) begin
      out_item_r.chain_frame <= frame;
      out_item_r.last_of_run <= last;
      out_item_r.pass_done   <= ctl.emit_row && done_r;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.col_last = (col_cnt_r == COL_W'(NCOL - 1));
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

endmodule
`default_nettype wire

// ===== rtl/led_matrix_text_scroller_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_text_scroller_unit: scrolling text engine for a chain of
// 8x8 LED matrix driver modules
// Usage: commands arrive on the in_ channel (valid/ready), chain frames leave
// on the out_ channel (valid/ready), intensity and text length are written
// over the APB port (register 0 at 0x0, register 1 at 0x4) while idle.
// A write command produces no frame. An init command produces 13
// frames, one per cycle when the receiver keeps up. A step command walks
// the 8*MODULES screen columns, each in an address state and a data state
// because the text RAM read is registered, then sends 8 row frames.
// Commands are taken one at a time; in_ready is high while no command is
// in progress, even if the last frame still waits.
// When the receiver stalls, the pending frame holds in the output register
// and the sequencer waits. Reset (synchronous, active low) sets intensity 8,
// text length 0 and offset 8*MODULES; the text store is undefined until
// written.
// ----------------------------------------------------------------------------
module led_matrix_text_scroller_unit import lmts_pkg::*; #(
  parameter int MODULES  = 4,
  parameter int TEXT_MAX = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire lmts_in_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output lmts_out_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [3:0] intensity_r, intensity_nxt;
  logic [6:0] text_len_r, text_len_nxt;
  logic       cfg_wr;
  lmts_ctl_t  ctl;
  lmts_sts_t  sts;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    intensity_nxt = intensity_r;
    text_len_nxt  = text_len_r;
    if (cfg_wr) begin
      if (paddr[2] == REG_IDX_INTENSITY) begin
        intensity_nxt = pwdata[3:0];
      end else begin
        text_len_nxt = pwdata[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r <= 4'd8;
      text_len_r  <= 7'd0;
    end else begin
      intensity_r <= intensity_nxt;
      text_len_r  <= text_len_nxt;
    end
  end

  // Register readback
  always_comb begin
    if (paddr[2] == REG_IDX_TEXT_LEN) begin
      prdata = {25'd0, text_len_r};
    end else begin
      prdata = {28'd0, intensity_r};
    end
  end

  lmts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_item.command),
    .sts        (sts),
    .ctl        (ctl)
  );

  lmts_dp #(
    .MODULES  (MODULES),
    .TEXT_MAX (TEXT_MAX)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .char_code   (in_item.char_code),
    .char_pos    (in_item.char_pos),
    .intensity   (intensity_r),
    .text_length (text_len_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

`ifndef SYNTH
  // A frame-producing command blocks the input on the next cycle
  a_busy_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && ((in_item.command == CMD_INIT) ||
                              (in_item.command == CMD_STEP))) |=> !in_ready)
    else $error("input not blocked after init or step transfer");

  // Pass-done frames are always row frames
  a_done_on_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.pass_done) |->
    ((out_item.chain_frame[15:8] != 8'h00) && (out_item.chain_frame[15:8] <= 8'h08)))
    else $error("pass_done on a frame that is not a row frame");

  // Bits above the populated modules stay zero
  a_unused_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.chain_frame >> (16 * MODULES)) == 64'd0))
    else $error("frame bits above the chain are set");
`endif

endmodule
`default_nettype wire
